>>> hw/rtl/equirect_to_cubemap_address_assert.svh
// Assertion macros for the equirect-to-cubemap address block.
// Expects signals clk and rst_n in the scope of use.
`ifndef EQUIRECT_TO_CUBEMAP_ADDRESS_ASSERT_SVH
`define EQUIRECT_TO_CUBEMAP_ADDRESS_ASSERT_SVH

// same-cycle implication, held off during reset
`define E2C_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2c: implication check failed");

// next-cycle implication, held off during reset
`define E2C_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2c: next-cycle check failed");

`endif

>>> hw/rtl/e2c_pkg.sv
// Shared types, constants and the face basis for the equirect-to-cubemap block.
// No dependencies.
package e2c_pkg;

    localparam int ANG_W   = 18;   // angle, fraction of a turn
    localparam int TAB_LEN = 24;
    localparam int CW      = 22;   // CORDIC datapath width
    localparam int DW      = 30;   // divider remainder width
    localparam int QW      = 17;   // divider quotient width
    localparam int FS_W    = 13;   // effective face size width
    localparam int D_W     = 18;   // direction component width

    localparam logic [ANG_W-1:0] HALF_TURN = 18'h20000;
    localparam logic [16:0]      INV_GAIN  = 17'd39797;

    localparam logic [ANG_W-1:0] ATAN_TURN [TAB_LEN] = '{
        18'd32768, 18'd19344, 18'd10221, 18'd5188, 18'd2604, 18'd1303, 18'd652, 18'd326,
        18'd163, 18'd81, 18'd41, 18'd20, 18'd10, 18'd5, 18'd3, 18'd1,
        18'd1, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0
    };

    typedef enum logic [1:0] {
        REG_FACE_SIZE    = 2'd0,
        REG_SRC_WIDTH    = 2'd1,
        REG_SRC_HEIGHT   = 2'd2,
        REG_SRC_CHANNELS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  face;
        logic [10:0] tx;
        logic [10:0] ty;
    } texel_t;

    typedef struct packed {
        logic [DW-1:0] rem_u;
        logic [DW-1:0] rem_v;
        logic [QW-1:0] q_u;
        logic [QW-1:0] q_v;
    } div_lanes_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic [ANG_W-1:0]     acc;
    } cordic_t;

    typedef struct packed {
        logic signed [D_W-1:0] x;
        logic signed [D_W-1:0] y;
        logic signed [D_W-1:0] z;
    } dir_t;

    // forward + u*right + v*up per face; faces 6 and 7 fold onto -Z
    function automatic dir_t face_dir(input logic [2:0] face,
                                      input logic signed [D_W-1:0] u,
                                      input logic signed [D_W-1:0] v);
        dir_t d;
        logic signed [D_W-1:0] one;
        one = 18'sd65536;
        case (face)
            3'd0:    begin d.x = -one; d.y = -v;   d.z = -u;   end
            3'd1:    begin d.x = one;  d.y = -v;   d.z = u;    end
            3'd2:    begin d.x = -u;   d.y = one;  d.z = v;    end
            3'd3:    begin d.x = -u;   d.y = -one; d.z = -v;   end
            3'd4:    begin d.x = -u;   d.y = -v;   d.z = one;  end
            default: begin d.x = u;    d.y = -v;   d.z = -one; end
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/equirect_to_cubemap_address.sv
// Top level of the equirect-to-cubemap address generator.
// Depends on e2c_pkg, e2c_div_cell, e2c_cordic_cell and the assert header.
//
// Input channel s_*: one item per cubemap texel (face, column, row).
// Output channel m_*: one item per input with source column, source row,
// source element index and cubemap element index, in input order.
// Configuration: cfg_we/cfg_index/cfg_data write face_size, src_width,
// src_height and src_channels; write only while no item is in flight.
// Throughput: one item per cycle while the skid register is empty. The
// pipeline holds the 17-cell divider row for u and v, the two CORDIC
// cell rows and the output stages.
// Reset clears all valid flags and loads the default registers
// (512, 2048, 1024, 4).
// When m_tready is low the result is held in the output register and one
// more item lands in a skid register; the whole pipeline then freezes and
// s_tready drops until the skid register drains.
module equirect_to_cubemap_address
    import e2c_pkg::*;
#(
    parameter int MAX_FACE_SIZE = 2048,
    parameter int MAX_SRC_WIDTH = 8192,
    parameter int CORDIC_STEPS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // face[2:0], tex_x[13:3], tex_y[24:14], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // src_x[12:0], src_y[24:13], src_index[51:25],
                                   // out_index[78:52], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int TEX_W  = $bits(texel_t);
    localparam int SIDE_W = D_W + TEX_W;
    localparam int W_W    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int PW     = 28;
    localparam int OUT_W  = 79;

    // configuration
    logic [11:0] face_size_reg;
    logic [13:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [2:0]  src_channels_reg;
    logic [FS_W-1:0] fs;
    logic [W_W-1:0]  w;
    logic [12:0]     h;
    logic            ch4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg    <= 12'd512;
            src_width_reg    <= 14'd2048;
            src_height_reg   <= 13'd1024;
            src_channels_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FACE_SIZE:    face_size_reg    <= cfg_data[11:0];
                REG_SRC_WIDTH:    src_width_reg    <= cfg_data;
                REG_SRC_HEIGHT:   src_height_reg   <= cfg_data[12:0];
                REG_SRC_CHANNELS: src_channels_reg <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (face_size_reg == 12'd0)
            fs = FS_W'(1);
        else if (32'(face_size_reg) > MAX_FACE_SIZE)
            fs = FS_W'(MAX_FACE_SIZE);
        else
            fs = FS_W'(face_size_reg);
        if (src_width_reg == 14'd0)
            w = W_W'(1);
        else if (32'(src_width_reg) > MAX_SRC_WIDTH)
            w = W_W'(MAX_SRC_WIDTH);
        else
            w = W_W'(src_width_reg);
        if (src_height_reg == 13'd0)
            h = 13'd1;
        else if (src_height_reg > 13'd4096)
            h = 13'd4096;
        else
            h = src_height_reg;
        ch4 = (src_channels_reg >= 3'd4);
    end

    // stall control: everything advances unless the skid register is full
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input stage: clamp and seed the divider
    logic       v0_reg;
    texel_t     tex0_reg;
    div_lanes_t div0_reg;
    texel_t     tex_in;
    logic [11:0] nu;
    logic [11:0] nv;

    always_comb
    begin
        tex_in.face = (s_tdata[2:0] > 3'd5) ? 3'd5 : s_tdata[2:0];
        tex_in.tx   = (FS_W'(s_tdata[13:3]) >= fs) ? 11'(fs - 1'b1) : s_tdata[13:3];
        tex_in.ty   = (FS_W'(s_tdata[24:14]) >= fs) ? 11'(fs - 1'b1) : s_tdata[24:14];
        nu = {tex_in.tx, 1'b1};
        nv = {tex_in.ty, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex0_reg       <= tex_in;
            div0_reg.rem_u <= DW'(nu) << 16;
            div0_reg.rem_v <= DW'(nv) << 16;
            div0_reg.q_u   <= '0;
            div0_reg.q_v   <= '0;
        end
    end

    // divider row, quotient msb first
    logic             dv   [QW+1];
    div_lanes_t       dd   [QW+1];
    logic [TEX_W-1:0] dsd  [QW+1];

    assign dv[0]  = v0_reg;
    assign dd[0]  = div0_reg;
    assign dsd[0] = tex0_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        e2c_div_cell #(.BIT(QW - 1 - i), .SIDE_W(TEX_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .divisor(fs),
            .in_valid(dv[i]), .in_data(dd[i]), .in_side(dsd[i]),
            .out_valid(dv[i+1]), .out_data(dd[i+1]), .out_side(dsd[i+1])
        );
    end

    // direction from the face basis
    logic   vdir_reg;
    dir_t   dir_reg;
    texel_t texd_reg;
    logic signed [D_W-1:0] u_s;
    logic signed [D_W-1:0] v_s;

    assign u_s = $signed({1'b0, dd[QW].q_u}) - 18'sd65536;
    assign v_s = $signed({1'b0, dd[QW].q_v}) - 18'sd65536;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vdir_reg <= 1'b0;
        else if (en)
            vdir_reg <= dv[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_reg  <= face_dir(dsd[QW][24:22], u_s, v_s);
            texd_reg <= dsd[QW];
        end
    end

    // CORDIC for longitude: atan2(z, x)
    logic              vp1_reg;
    cordic_t           p1_reg;
    logic [SIDE_W-1:0] s1_reg;
    logic signed [CW-1:0] dx_w;
    logic signed [CW-1:0] dz_w;

    assign dx_w = CW'(dir_reg.x);
    assign dz_w = CW'(dir_reg.z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp1_reg <= 1'b0;
        else if (en)
            vp1_reg <= vdir_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg.a   <= dx_w[CW-1] ? -dx_w : dx_w;
            p1_reg.b   <= dx_w[CW-1] ? -dz_w : dz_w;
            p1_reg.acc <= dx_w[CW-1] ? HALF_TURN : '0;
            s1_reg     <= {dir_reg.y, texd_reg};
        end
    end

    logic              c1v [CORDIC_STEPS+1];
    cordic_t           c1d [CORDIC_STEPS+1];
    logic [SIDE_W-1:0] c1s [CORDIC_STEPS+1];

    assign c1v[0] = vp1_reg;
    assign c1d[0] = p1_reg;
    assign c1s[0] = s1_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_c1
        e2c_cordic_cell #(.SHIFT(i), .ANGLE(ATAN_TURN[i]), .SIDE_W(SIDE_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(c1v[i]), .in_data(c1d[i]), .in_side(c1s[i]),
            .out_valid(c1v[i+1]), .out_data(c1d[i+1]), .out_side(c1s[i+1])
        );
    end

    // gain correction of the horizontal magnitude
    logic                  vg_reg;
    logic signed [CW-1:0]  r_reg;
    logic [ANG_W-1:0]      theta_reg;
    logic signed [D_W-1:0] dy_reg;
    texel_t                texg_reg;
    logic signed [CW+17:0] gprod;

    assign gprod = c1d[CORDIC_STEPS].a * $signed({1'b0, INV_GAIN});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vg_reg <= 1'b0;
        else if (en)
            vg_reg <= c1v[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= gprod[CW+15:16];
            theta_reg <= c1d[CORDIC_STEPS].acc;
            dy_reg    <= c1s[CORDIC_STEPS][SIDE_W-1:TEX_W];
            texg_reg  <= c1s[CORDIC_STEPS][TEX_W-1:0];
        end
    end

    // CORDIC for latitude: atan2(y, r)
    logic              vp2_reg;
    cordic_t           p2_reg;
    logic [SIDE_W-1:0] s2_reg;
    logic signed [CW-1:0] dy_w;

    assign dy_w = CW'(dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp2_reg <= 1'b0;
        else if (en)
            vp2_reg <= vg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg.a   <= r_reg[CW-1] ? -r_reg : r_reg;
            p2_reg.b   <= r_reg[CW-1] ? -dy_w : dy_w;
            p2_reg.acc <= r_reg[CW-1] ? HALF_TURN : '0;
            s2_reg     <= {theta_reg, texg_reg};
        end
    end

    logic              c2v [CORDIC_STEPS+1];
    cordic_t           c2d [CORDIC_STEPS+1];
    logic [SIDE_W-1:0] c2s [CORDIC_STEPS+1];

    assign c2v[0] = vp2_reg;
    assign c2d[0] = p2_reg;
    assign c2s[0] = s2_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_c2
        e2c_cordic_cell #(.SHIFT(i), .ANGLE(ATAN_TURN[i]), .SIDE_W(SIDE_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(c2v[i]), .in_data(c2d[i]), .in_side(c2s[i]),
            .out_valid(c2v[i+1]), .out_data(c2d[i+1]), .out_side(c2s[i+1])
        );
    end

    // stage A: angles to pixel coordinates, first index product
    logic             va_reg;
    logic [W_W-1:0]   sxa_reg;
    logic [13:0]      sya_reg;
    logic             neg_reg;
    logic [15:0]      fi_reg;
    texel_t           texa_reg;
    logic [ANG_W-1:0] th;
    logic [ANG_W-1:0] ph;
    logic [ANG_W-1:0] tx_turn;
    logic signed [ANG_W:0] ty_turn;
    logic [ANG_W+W_W-1:0]  sx_prod;
    logic [ANG_W+12:0]     sy_prod;
    texel_t                tex2;

    always_comb
    begin
        th      = c2s[CORDIC_STEPS][SIDE_W-1:TEX_W];
        tex2    = c2s[CORDIC_STEPS][TEX_W-1:0];
        ph      = c2d[CORDIC_STEPS].acc;
        tx_turn = {~th[ANG_W-1], th[ANG_W-2:0]};
        ty_turn = $signed({ph[ANG_W-1], ph}) + 19'sd65536;
        sx_prod = (ANG_W+W_W)'(tx_turn) * (ANG_W+W_W)'(w);
        sy_prod = (ANG_W+13)'(ty_turn[ANG_W-1:0]) * (ANG_W+13)'(h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= c2v[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxa_reg  <= sx_prod[ANG_W+W_W-1:ANG_W];
            sya_reg  <= sy_prod[30:17];
            neg_reg  <= ty_turn[ANG_W];
            fi_reg   <= 16'(tex2.face) * 16'(fs) + 16'(tex2.ty);
            texa_reg <= tex2;
        end
    end

    // stage B: clamp row, finish cubemap texel number
    logic           vb_reg;
    logic [W_W-1:0] sxb_reg;
    logic [11:0]    syb_reg;
    logic [PW-1:0]  pb_reg;
    logic [11:0]    sy_next;

    always_comb
    begin
        if (neg_reg)
            sy_next = '0;
        else if (sya_reg > 14'(h - 1'b1))
            sy_next = 12'(h - 1'b1);
        else
            sy_next = sya_reg[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxb_reg <= sxa_reg;
            syb_reg <= sy_next;
            pb_reg  <= PW'(fi_reg) * PW'(fs) + PW'(texa_reg.tx);
        end
    end

    // stage C: source pixel number, cubemap element index
    logic           vc_reg;
    logic [W_W-1:0] sxc_reg;
    logic [11:0]    syc_reg;
    logic [PW-1:0]  spc_reg;
    logic [26:0]    oic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxc_reg <= sxb_reg;
            syc_reg <= syb_reg;
            spc_reg <= PW'(syb_reg) * PW'(w) + PW'(sxb_reg);
            oic_reg <= {pb_reg[24:0], 2'b00};
        end
    end

    // stage D: channel scaling, packing
    logic             fin_valid_reg;
    logic [OUT_W-1:0] fin_reg;
    logic [PW+1:0]    si_full;

    assign si_full = ch4 ? {spc_reg, 2'b00} : ({1'b0, spc_reg, 1'b0} + (PW+2)'(spc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (en)
            fin_valid_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= {oic_reg, si_full[26:0], syc_reg, sxc_reg[12:0]};
    end

    // output register with skid
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= fin_valid_reg;
        end
        else if (en && fin_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (en)
                out_reg <= fin_reg;
        end
        else if (en && fin_valid_reg)
            skid_reg <= fin_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

`include "equirect_to_cubemap_address_assert.svh"

    `E2C_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `E2C_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v0_reg)
    `E2C_ASSERT_IMPL(a_row_in_range, m_tvalid, 13'(m_tdata[24:13]) < h)
    `E2C_ASSERT_IMPL(a_col_in_range, m_tvalid, W_W'(m_tdata[12:0]) < w)

endmodule

>>> hw/rtl/e2c_div_cell.sv
// One quotient bit of the restoring divider, two lanes (u and v).
// Depends on e2c_pkg.
module e2c_div_cell
    import e2c_pkg::*;
#(
    parameter int BIT    = 0,
    parameter int SIDE_W = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [FS_W-1:0]   divisor,
    input  logic              in_valid,
    input  div_lanes_t        in_data,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output div_lanes_t        out_data,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    div_lanes_t        data_reg;
    div_lanes_t        data_next;
    logic [SIDE_W-1:0] side_reg;
    logic [DW-1:0]     dsh;

    always_comb
    begin
        dsh = {{(DW-FS_W){1'b0}}, divisor} << BIT;
        data_next = in_data;
        if (in_data.rem_u >= dsh)
        begin
            data_next.rem_u = in_data.rem_u - dsh;
            data_next.q_u[BIT] = 1'b1;
        end
        if (in_data.rem_v >= dsh)
        begin
            data_next.rem_v = in_data.rem_v - dsh;
            data_next.q_v[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

>>> hw/rtl/e2c_cordic_cell.sv
// One vectoring CORDIC micro-rotation with a side band carried alongside.
// Depends on e2c_pkg.
module e2c_cordic_cell
    import e2c_pkg::*;
#(
    parameter int               SHIFT  = 0,
    parameter logic [ANG_W-1:0] ANGLE  = 18'd0,
    parameter int               SIDE_W = 43
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_t           in_data,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_t           out_data,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    cordic_t           data_reg;
    cordic_t           data_next;
    logic [SIDE_W-1:0] side_reg;
    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [CW-1:0] a_sh;
    logic signed [CW-1:0] b_sh;

    always_comb
    begin
        a_in = in_data.a;
        b_in = in_data.b;
        a_sh = a_in >>> SHIFT;
        b_sh = b_in >>> SHIFT;
        if (!b_in[CW-1])
        begin
            data_next.a   = a_in + b_sh;
            data_next.b   = b_in - a_sh;
            data_next.acc = in_data.acc + ANGLE;
        end
        else
        begin
            data_next.a   = a_in - b_sh;
            data_next.b   = b_in + a_sh;
            data_next.acc = in_data.acc - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

>>> dv/tb.sv
// Self-checking testbench for equirect_to_cubemap_address.
// Needs e2c_pkg and the block's RTL; a scoreboard class predicts each texel's addresses.

import e2c_pkg::*;

typedef struct packed {
    logic [26:0] out_index;
    logic [26:0] src_index;
    logic [11:0] src_y;
    logic [12:0] src_x;
} addr_res_t;

class addr_scoreboard;
    int unsigned face_size, src_width, src_height, src_channels;
    addr_res_t   pending[$];
    int          errors;

    function void set_reg(cfg_reg_t idx, int unsigned val);
        case (idx)
            REG_FACE_SIZE:    face_size    = val & 12'hFFF;
            REG_SRC_WIDTH:    src_width    = val & 14'h3FFF;
            REG_SRC_HEIGHT:   src_height   = val & 13'h1FFF;
            REG_SRC_CHANNELS: src_channels = val & 3'h7;
            default:          ;
        endcase
    endfunction

    function void defaults();
        face_size = 512; src_width = 2048; src_height = 1024; src_channels = 4;
    endfunction

    function int unsigned eff_face();
        return face_size < 1 ? 1 : (face_size > 2048 ? 2048 : face_size);
    endfunction

    // vectoring rotation; returns wrapped turn fraction, magnitude out
    function longint vector_angle(longint a, longint b, output longint mag);
        longint acc, na, nb;
        logic [17:0] w;
        acc = 0;
        if (a < 0)
        begin
            a = -a; b = -b; acc = 131072;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (b >= 0)
            begin
                na = a + (b >>> i); nb = b - (a >>> i); acc += ATAN_TURN[i];
            end
            else
            begin
                na = a - (b >>> i); nb = b + (a >>> i); acc -= ATAN_TURN[i];
            end
            a = na; b = nb;
        end
        mag = a;
        w = acc[17:0];
        return longint'($signed(w));
    endfunction

    function void note_texel(logic [2:0] face_in, logic [10:0] tx_in, logic [10:0] ty_in);
        longint fs, w, h, ch, face, tx, ty, u, v, dx, dy, dz, mag, r, theta, phi, sx, sy, t;
        addr_res_t e;
        fs = eff_face();
        w  = src_width < 1 ? 1 : (src_width > 8192 ? 8192 : src_width);
        h  = src_height < 1 ? 1 : (src_height > 4096 ? 4096 : src_height);
        ch = src_channels < 3 ? 3 : (src_channels > 4 ? 4 : src_channels);
        face = face_in > 5 ? 5 : face_in;
        tx = tx_in >= fs ? fs - 1 : tx_in;
        ty = ty_in >= fs ? fs - 1 : ty_in;
        u = (((2 * tx + 1) << 16) / fs) - 65536;
        v = (((2 * ty + 1) << 16) / fs) - 65536;
        case (face)
            0: begin dx = -65536; dy = -v; dz = -u; end
            1: begin dx = 65536;  dy = -v; dz = u;  end
            2: begin dx = -u; dy = 65536;  dz = v;  end
            3: begin dx = -u; dy = -65536; dz = -v; end
            4: begin dx = -u; dy = -v; dz = 65536;  end
            default: begin dx = u; dy = -v; dz = -65536; end
        endcase
        theta = vector_angle(dx, dz, mag);
        r = (mag * 39797) >>> 16;
        phi = vector_angle(r, dy, mag);
        sx = ((theta + 131072) * w) >> 18;
        t = phi + 65536;
        if (t < 0)
            sy = 0;
        else
        begin
            sy = (t * h) >> 17;
            if (sy > h - 1) sy = h - 1;
        end
        e.src_x     = sx[12:0];
        e.src_y     = sy[11:0];
        e.src_index = 27'((sy * w + sx) * ch);
        e.out_index = 27'(((face * fs + ty) * fs + tx) * 4);
        pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_result(addr_res_t got);
        addr_res_t e;
        if (pending.size() == 0)
        begin
            report("unexpected item", got.src_x, -1);
            return;
        end
        e = pending.pop_front();
        if (got.src_x !== e.src_x)         report("src_x", got.src_x, e.src_x);
        if (got.src_y !== e.src_y)         report("src_y", got.src_y, e.src_y);
        if (got.src_index !== e.src_index) report("src_index", got.src_index, e.src_index);
        if (got.out_index !== e.out_index) report("out_index", got.out_index, e.out_index);
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // face[2:0], tex_x[13:3], tex_y[24:14]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;        // src_x, src_y, src_index, out_index, zero fill
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;

    addr_scoreboard sb = new();
    bit  no_idle = 0;
    bit  hold_done = 0;
    int  quiet = 0;
    int  results = 0;

    equirect_to_cubemap_address uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_texel(logic [2:0] face, logic [10:0] tx, logic [10:0] ty);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'd0, ty, tx, face};
        do @(posedge clk); while (!s_tready);
        sb.note_texel(face, tx, ty);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val[13:0];
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic random_texels(int n);
        int unsigned fs;
        logic [10:0] tx, ty;
        fs = sb.eff_face();
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i % 60) < 15;
            tx = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, fs - 1));
            ty = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, fs - 1));
            send_texel(3'($urandom_range(0, 7)), tx, ty);
        end
        no_idle = 0;
    endtask

    // receiver: random back-pressure, one long hold-off once results flow
    always
    begin
        if (!hold_done && results > 100)
        begin
            hold_done = 1;
            m_tready <= 0;
            repeat (300) @(posedge clk);
        end
        if (!no_idle && $urandom_range(0, 49) == 0)
        begin
            m_tready <= 0;
            repeat ($urandom_range(10, 40)) @(posedge clk);
        end
        m_tready <= (no_idle || $urandom_range(0, 99) < 70) ? 1'b1
                  : ($urandom_range(0, 19) == 0 ? 1'b0 : 1'b1);
        @(posedge clk);
        if (m_tvalid && m_tready)
        begin
            results++;
            sb.check_result(m_tdata[78:0]);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int unsigned settings[7][4] = '{
            '{1, 1, 1, 3}, '{2048, 8192, 4096, 4}, '{4095, 16383, 8191, 7},
            '{0, 0, 0, 0}, '{16, 100, 50, 2}, '{3, 5000, 2500, 4}, '{512, 2048, 1024, 4}
        };
        sb.defaults();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // corners of every face, centres of faces 1 to 3, folded faces, texels past the edge
        for (int f = 0; f < 8; f++)
            send_texel(3'(f), 11'd0, 11'd0);
        send_texel(3'd0, 11'd511, 11'd511);
        send_texel(3'd1, 11'd255, 11'd256);
        send_texel(3'd2, 11'd256, 11'd255);
        send_texel(3'd3, 11'd511, 11'd0);
        send_texel(3'd4, 11'd0, 11'd511);
        send_texel(3'd5, 11'd2047, 11'd2047);
        send_texel(3'd6, 11'd1024, 11'd100);
        send_texel(3'd7, 11'd100, 11'd2047);
        send_texel(3'd2, 11'd256, 11'd256);
        send_texel(3'd3, 11'd255, 11'd255);
        random_texels(250);
        drain();

        foreach (settings[k])
        begin
            write_reg(REG_FACE_SIZE,    settings[k][0]);
            write_reg(REG_SRC_WIDTH,    settings[k][1]);
            write_reg(REG_SRC_HEIGHT,   settings[k][2]);
            write_reg(REG_SRC_CHANNELS, settings[k][3]);
            send_texel(3'd5, 11'd2047, 11'd2047);
            send_texel(3'd2, 11'd0, 11'd2047);
            random_texels(140);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
